FILE: rtl/assert_macros.svh
// assertion macros for the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clk edge outside reset
`define CKE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising clk edge outside reset
`define CKE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cke_pkg.sv
// shared types and constants for the k7 convolutional encoder with pam4 mapping
package cke_pkg;

    localparam int BYTE_W = 8;
    localparam int MEM_W  = 6;
    localparam int WIN_W  = MEM_W + 1;
    localparam int LVL_W  = 3;
    localparam int N_LVL  = BYTE_W;
    localparam int SEQ_W  = MEM_W + BYTE_W;

    localparam logic [WIN_W-1:0] GEN_A = 7'h79;
    localparam logic [WIN_W-1:0] GEN_B = 7'h5B;

    typedef logic [BYTE_W-1:0]       byte_t;
    typedef logic [MEM_W-1:0]        mem_t;
    typedef logic signed [LVL_W-1:0] level_t;
    typedef level_t [N_LVL-1:0]      level_vec_t;

endpackage

FILE: rtl/cke_encoder.sv
// combinational eight-bit unrolled convolutional encoder and pam4 level mapper
module cke_encoder
(
    input  cke_pkg::mem_t       mem,
    input  cke_pkg::byte_t      data_byte,
    input  logic                message_start,
    output cke_pkg::level_vec_t levels,
    output cke_pkg::mem_t       mem_next
);

    logic [cke_pkg::SEQ_W-1:0] seq;
    cke_pkg::mem_t             mem_eff;

    assign mem_eff = message_start ? '0 : mem;
    // oldest bit on top, newest byte bit at the bottom
    assign seq = {mem_eff, data_byte};
    // after eight shifts the memory holds the low six bits of the byte
    assign mem_next = data_byte[cke_pkg::MEM_W-1:0];

    always_comb
    begin
        logic [cke_pkg::WIN_W-1:0] win;
        logic                      pa;
        logic                      pb;
        for (int k = 0; k < cke_pkg::N_LVL; k++)
        begin
            win = seq[cke_pkg::SEQ_W-1-k -: cke_pkg::WIN_W];
            pa  = ^(win & cke_pkg::GEN_A);
            pb  = ^(win & cke_pkg::GEN_B);
            // 2q-3 with q = {pa, pb}: 0->-3, 1->-1, 2->1, 3->3
            levels[k] = {~pa, pb, 1'b1};
        end
    end

endmodule

FILE: rtl/conv_k7_encoder_pam4_mapper.sv
// top level: k7 rate 1/2 convolutional encoder (0x79, 0x5B) with pam4 level output
//
//  channel   dir  tdata                                    tuser
//  s_axis    in   [7:0] data_byte                          [0] message_start
//  m_axis    out  [23:0] level_0 .. level_7, 3 bits each   none
//
// one byte per clock sustained while m_axis_tready stays high; the input register
// loads at the input transfer and feeds the result register whenever that can load
// the encoder memory updates as a byte moves from the input register to the
// result register, so back-to-back bytes chain through it with no gap
// rst_n clears both valid flags and the encoder memory
// a stalled m_axis holds the result; an empty input register still takes one
// more byte, then s_axis_tready drops until the result is taken
`include "assert_macros.svh"

module conv_k7_encoder_pam4_mapper
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] message_start

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [2:0] level_0 .. [23:21] level_7
);

    // input register
    logic                in_valid_reg;
    logic                in_valid_next;
    cke_pkg::byte_t      byte_reg;
    logic                start_reg;

    // encoder state
    cke_pkg::mem_t       mem_reg;
    cke_pkg::mem_t       mem_next;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    cke_pkg::level_vec_t levels_reg;
    cke_pkg::level_vec_t levels_next;

    logic                in_xfer;
    logic                out_ready;
    logic                advance;

    // helpers for the checks below
    logic                levels_odd;
    cke_pkg::mem_t       byte_tail;
    logic                pipe_full;

    // result stage can load when empty or when its content leaves this cycle
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_ready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign advance       = in_valid_reg && out_ready;

    cke_encoder u_enc
    (
        .mem           (mem_reg),
        .data_byte     (byte_reg),
        .message_start (start_reg),
        .levels        (levels_next),
        .mem_next      (mem_next)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mem_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                mem_reg <= mem_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            byte_reg  <= s_axis_tdata;
            start_reg <= s_axis_tuser;
        end
        if (advance)
            levels_reg <= levels_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = levels_reg;

    assign levels_odd = m_axis_tdata[0] && m_axis_tdata[3] && m_axis_tdata[6]
                        && m_axis_tdata[9] && m_axis_tdata[12] && m_axis_tdata[15]
                        && m_axis_tdata[18] && m_axis_tdata[21];
    assign byte_tail  = byte_reg[cke_pkg::MEM_W-1:0];
    assign pipe_full  = in_valid_reg && out_valid_reg && !m_axis_tready;

    // every pam4 level is odd
    `CKE_ASSERT_IMPL(a_levels_odd, m_axis_tvalid, levels_odd, "pam4 level with even code")
    // after a byte is encoded the memory holds its six low bits
    `CKE_ASSERT_NEXT(a_mem_update, advance, mem_reg == $past(byte_tail), "memory not loaded from byte")
    // input side only stalls when both registers are full and the sink stalls
    `CKE_ASSERT_IMPL(a_stall_cause, !s_axis_tready, pipe_full, "input stalled without a full pipeline")
    // an encoded byte always lands in the result register
    `CKE_ASSERT_NEXT(a_result_valid, advance, out_valid_reg, "result lost after encode")

endmodule

FILE: test/conv_k7_encoder_pam4_mapper_checker.sv
// stream monitor, pam4 level predictor and result scoreboard for the k7 encoder
`timescale 1ns / 100ps

module conv_k7_encoder_pam4_mapper_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] message_start

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [2:0] level_0 .. [23:21] level_7

    output int          fail_count,
    output int          levels_pending,
    output int          results_seen
);

    localparam int MAX_PRINTED = 40;

    cke_pkg::mem_t       coder_mem = '0;
    cke_pkg::level_vec_t levels_due[$];
    int                  mismatches = 0;
    int                  checked = 0;

    // one line per mismatch, printing stops after a while but counting goes on
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // levels of one byte, msb first, starting from the given coder memory
    function automatic cke_pkg::level_vec_t pam4_levels(input cke_pkg::mem_t mem_in,
                                                        input cke_pkg::byte_t data);
        logic [cke_pkg::WIN_W-1:0] win;
        cke_pkg::mem_t             mem;
        logic                      par_a;
        logic                      par_b;
        int                        q;
        cke_pkg::level_vec_t       lv;
        mem = mem_in;
        for (int k = 0; k < cke_pkg::N_LVL; k++)
        begin
            win   = {mem, data[cke_pkg::N_LVL-1-k]};
            par_a = ^(win & cke_pkg::GEN_A);
            par_b = ^(win & cke_pkg::GEN_B);
            q     = 2 * par_a + par_b;
            lv[k] = cke_pkg::level_t'(2 * q - 3);
            mem   = win[cke_pkg::MEM_W-1:0];
        end
        return lv;
    endfunction

    always @(posedge clk)
    begin
        cke_pkg::level_vec_t want;
        cke_pkg::level_t     got;
        if (!rst_n)
        begin
            coder_mem = '0;
        end
        else
        begin
            // results first, a byte taken at this edge cannot show up yet
            if (m_axis_tvalid && m_axis_tready)
            begin
                checked++;
                if (levels_due.size() == 0)
                begin
                    report_mismatch($sformatf("result %0h with no byte waiting",
                                              m_axis_tdata));
                end
                else
                begin
                    want = levels_due.pop_front();
                    for (int k = 0; k < cke_pkg::N_LVL; k++)
                    begin
                        got = m_axis_tdata[cke_pkg::LVL_W*k +: cke_pkg::LVL_W];
                        if (got !== want[k])
                            report_mismatch($sformatf("result %0d level_%0d got %0d want %0d",
                                                      checked, k, got, want[k]));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser)
                    coder_mem = '0;
                levels_due.insert(levels_due.size(), pam4_levels(coder_mem, s_axis_tdata));
                // after eight shifts the memory holds the low six bits of the byte
                coder_mem = s_axis_tdata[cke_pkg::MEM_W-1:0];
            end
        end
        fail_count     <= mismatches;
        levels_pending <= levels_due.size();
        results_seen   <= checked;
    end

endmodule

FILE: test/conv_k7_encoder_pam4_mapper_tb.sv
// top testbench for the k7 convolutional encoder with pam4 mapping
`timescale 1ns / 100ps

module conv_k7_encoder_pam4_mapper_tb;

    localparam int TOTAL_BYTES  = 620;
    localparam int HOLD_AT      = 420;  // sink hold-off starts once this many bytes went in
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 10;   // short latency plus margin

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;   // [0] message_start

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [2:0] level_0 .. [23:21] level_7

    int          fail_count;
    int          levels_pending;
    int          results_seen;

    int          bytes_sent = 0;
    int          starts_sent = 0;
    logic        hold_off = 1'b0;       // sink is holding off, source must keep offering
    bit          hold_done = 1'b0;

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    conv_k7_encoder_pam4_mapper u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    conv_k7_encoder_pam4_mapper_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .fail_count     (fail_count),
        .levels_pending (levels_pending),
        .results_seen   (results_seen)
    );

    // one byte transfer on s_axis, with random idle cycles ahead of it
    // no idling inside the steady window or while the sink holds off
    task automatic send_byte(input cke_pkg::byte_t data, input logic restart);
        while (!hold_off && !(bytes_sent >= 100 && bytes_sent < 220)
               && $urandom_range(0, 99) < 29)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= restart;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
        if (restart)
            starts_sent++;
    endtask

    // sink: random stalls, a stall-free window, and one long hold-off
    initial
    begin : sink
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!hold_done && bytes_sent >= HOLD_AT)
            begin
                // long hold-off so the pipeline fills and s_axis_tready drops
                hold_done = 1'b1;
                hold_off      <= 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
            else if (bytes_sent >= 260 && bytes_sent < 360)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= 29);
            end
            @(posedge clk);
        end
    end

    // source and verdict
    initial
    begin : source
        int             msg_len;
        logic           restart;
        cke_pkg::byte_t pattern;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: all-zero and all-one bytes, single bits, alternating
        // patterns, message start on a full memory and on an empty one,
        // bytes that chain through the memory without a start
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);     // start with a full memory
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h00, 1'b1);     // start with a memory that is not empty
        send_byte(8'h00, 1'b1);
        send_byte(8'h81, 1'b0);
        send_byte(8'h18, 1'b0);
        send_byte(8'hE7, 1'b1);
        send_byte(8'h3F, 1'b0);

        // random messages: mostly opened by a start, a few stray starts inside
        // and a few messages that simply run on from the previous one
        while (bytes_sent < TOTAL_BYTES)
        begin
            msg_len = $urandom_range(1, 24);
            for (int i = 0; i < msg_len; i++)
            begin
                if (i == 0)
                    restart = ($urandom_range(0, 99) < 90);
                else
                    restart = ($urandom_range(0, 99) < 4);
                pattern = cke_pkg::byte_t'($urandom_range(0, 255));
                send_byte(pattern, restart);
            end
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (levels_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d bytes with %0d message starts, %0d level results checked",
                 bytes_sent, starts_sent, results_seen);
        $display("with random idling on both sides and one %0d-cycle sink hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0 && levels_pending == 0)
        begin
            $display("PASS conv_k7_encoder_pam4_mapper");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", fail_count, levels_pending);
            $display("FAIL conv_k7_encoder_pam4_mapper");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin : watchdog
        #2_400_000;
        $display("timeout after %0d bytes", bytes_sent);
        $display("FAIL conv_k7_encoder_pam4_mapper");
        $finish;
    end

endmodule
